// File: rtl/euclidean_distance_accumulator_macros.svh
// Assertion macros shared by the distance accumulator RTL.
`ifndef EUCLIDEAN_DISTANCE_ACCUMULATOR_MACROS_SVH
`define EUCLIDEAN_DISTANCE_ACCUMULATOR_MACROS_SVH

// Condition holds at every clock edge outside reset.
`define EDA_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Consequent holds in the same cycle as the antecedent.
`define EDA_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// File: rtl/eda_pkg.sv
// Shared constants and types for the distance accumulator.
package eda_pkg;

  localparam int DEF_MAX_DIM    = 8192;
  localparam int DEF_COORD_BITS = 16;

  localparam int COORD_W      = 16;
  localparam int DIST_W       = 23;
  localparam int IN_TDATA_W   = 32;
  localparam int OUT_TDATA_W  = 24;
  localparam int QUEUE_DEPTH  = 4;

  typedef struct packed {
    logic full;
    logic empty;
  } eda_qstat_t;

endpackage

// File: rtl/eda_front.sv
// Front end: takes coordinate pairs, squares differences, accumulates per vector.
`include "euclidean_distance_accumulator_macros.svh"
module eda_front
  import eda_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int COORD_BITS = DEF_COORD_BITS,
  parameter int SUM_W      = 46
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               s_tvalid,
  output logic               s_tready,
  input  logic [COORD_W-1:0] coord_a,
  input  logic [COORD_W-1:0] coord_b,
  input  logic               s_tlast,
  input  eda_qstat_t         qstat,
  output logic               push,
  output logic [SUM_W:0]     push_data
);

  localparam int CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  localparam int SQ_W  = 2 * CW;

  logic [CNT_W-1:0] cnt;
  logic             ovf_seen;

  logic             s1_valid;
  logic [SQ_W-1:0]  s1_sq;
  logic             s1_last;
  logic             s1_ovf;

  logic [SUM_W-1:0] sum;
  logic [SUM_W-1:0] sum_next;

  logic [CW-1:0]    a;
  logic [CW-1:0]    b;
  logic [CW-1:0]    d;
  logic             room;
  logic             adv;
  logic             take;

  assign a    = coord_a[CW-1:0];
  assign b    = coord_b[CW-1:0];
  assign d    = (a >= b) ? (a - b) : (b - a);
  assign room = (cnt != CNT_W'(MAX_DIM));

  // stage 1 may move on unless a finished vector is blocked by a full queue
  assign adv      = !s1_valid || !s1_last || !qstat.full;
  assign s_tready = adv;
  assign take     = s_tvalid && adv;

  assign sum_next  = sum + SUM_W'(s1_sq);
  assign push      = s1_valid && s1_last && adv;
  assign push_data = {s1_ovf, sum_next};

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt      <= '0;
      ovf_seen <= 1'b0;
      s1_valid <= 1'b0;
      sum      <= '0;
    end else begin
      if (take) begin
        s1_valid <= 1'b1;
        if (s_tlast) begin
          cnt      <= '0;
          ovf_seen <= 1'b0;
        end else begin
          if (room) begin
            cnt <= cnt + 1'b1;
          end
          ovf_seen <= ovf_seen || !room;
        end
      end else if (adv) begin
        s1_valid <= 1'b0;
      end

      if (s1_valid && adv) begin
        if (s1_last) begin
          sum <= '0;
        end else begin
          sum <= sum_next;
        end
      end
    end
  end

  // squared difference register; dropped items add zero
  always_ff @(posedge clk) begin
    if (take) begin
      s1_sq   <= room ? (SQ_W'(d) * SQ_W'(d)) : '0;
      s1_last <= s_tlast;
      s1_ovf  <= ovf_seen || !room;
    end
  end

  `EDA_ASSERT_ALWAYS(a_cnt_bound, cnt <= CNT_W'(MAX_DIM), "element count above MAX_DIM")
  `EDA_ASSERT_IMPLY(a_no_push_full, push, !qstat.full, "push into full queue")

endmodule

// File: rtl/eda_queue.sv
// Small FIFO carrying finished sums from the front end to the square root unit.
`include "euclidean_distance_accumulator_macros.svh"
module eda_queue
  import eda_pkg::*;
#(
  parameter int W = 47
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  logic [W-1:0] wr_data,
  input  logic         pop,
  output logic [W-1:0] rd_data,
  output eda_qstat_t   qstat
);

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  logic [W-1:0]     mem [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign qstat.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign qstat.empty = (count == '0);
  assign rd_data     = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      unique case ({push, pop})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  `EDA_ASSERT_IMPLY(a_pop_empty, pop, !qstat.empty, "pop from empty queue")
  `EDA_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(QUEUE_DEPTH), "queue count overrun")

endmodule

// File: rtl/eda_sqrt.sv
// Back end: bit-serial integer square root and the result register.
`include "euclidean_distance_accumulator_macros.svh"
module eda_sqrt
  import eda_pkg::*;
#(
  parameter int SUM_W = 46
) (
  input  logic              clk,
  input  logic              rst,
  input  eda_qstat_t        qstat,
  input  logic [SUM_W:0]    rd_data,
  output logic              pop,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [DIST_W-1:0] distance,
  output logic              overflow
);

  localparam int ROOT_W = (SUM_W + 1) / 2;
  localparam int VAL_W  = 2 * ROOT_W;
  localparam int IT_W   = $clog2(ROOT_W + 1);

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  logic [1:0]        state;
  logic [VAL_W-1:0]  val;
  logic [ROOT_W:0]   rem;
  logic [ROOT_W-1:0] root;
  logic [IT_W-1:0]   it;
  logic              ovf;

  logic [ROOT_W+1:0] rem_sh;
  logic [ROOT_W+1:0] trial;
  logic [ROOT_W+1:0] diff;
  logic              ge;
  logic              slot_free;
  logic [ROOT_W+DIST_W-1:0] root_ext;

  assign rem_sh    = {rem[ROOT_W-1:0], val[VAL_W-1 -: 2]};
  assign trial     = {root, 2'b01};
  assign diff      = rem_sh - trial;
  assign ge        = (rem_sh >= trial);
  assign slot_free = !m_tvalid || m_tready;
  assign pop       = (state == ST_IDLE) && !qstat.empty;
  assign root_ext  = {{DIST_W{1'b0}}, root};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      it       <= '0;
      m_tvalid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (!qstat.empty) begin
            state <= ST_BUSY;
            it    <= '0;
          end
        end
        ST_BUSY: begin
          it <= it + 1'b1;
          if (it == IT_W'(ROOT_W - 1)) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (slot_free) begin
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
      // a new result refills the slot in the cycle the old one leaves
      if (state == ST_DONE && slot_free) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      val  <= VAL_W'(rd_data[SUM_W-1:0]);
      ovf  <= rd_data[SUM_W];
      rem  <= '0;
      root <= '0;
    end else if (state == ST_BUSY) begin
      val  <= {val[VAL_W-3:0], 2'b00};
      rem  <= ge ? diff[ROOT_W:0] : rem_sh[ROOT_W:0];
      root <= {root[ROOT_W-2:0], ge};
    end
    if (state == ST_DONE && slot_free) begin
      distance <= root_ext[DIST_W-1:0];
      overflow <= ovf;
    end
  end

  `EDA_ASSERT_IMPLY(a_iter_bound, state == ST_BUSY, it < IT_W'(ROOT_W), "root iteration overrun")

endmodule

// File: rtl/euclidean_distance_accumulator.sv
// Throughput: one coordinate pair per cycle unless a sum waits on a full queue; the
//   bit-serial root unit takes vectors singly; ROOT_W = ceil((2*CW + count bits) / 2).
// A 4-entry queue holds finished sums, so short vectors stall input only when it fills.
// Reset (rst, synchronous, active high) clears the accumulator, element count,
//   overflow flag, queue and result valid.
module euclidean_distance_accumulator
  import eda_pkg::*;
#(
  parameter int MAX_DIM    = DEF_MAX_DIM,
  parameter int COORD_BITS = DEF_COORD_BITS
) (
  input  logic                   clk,
  input  logic                   rst,
  // request in: one coordinate pair
  input  logic                   s_tvalid,
  output logic                   s_tready,
  input  logic [IN_TDATA_W-1:0]  s_tdata,   // [15:0] coord_a, [31:16] coord_b
  input  logic                   s_tlast,   // last_element
  // request out: one distance per vector
  output logic                   m_tvalid,
  input  logic                   m_tready,
  output logic [OUT_TDATA_W-1:0] m_tdata,   // [22:0] distance, [23] zero pad
  output logic                   m_tuser    // overflow
);

  localparam int CW    = (COORD_BITS < COORD_W) ? COORD_BITS : COORD_W;
  localparam int CNT_W = $clog2(MAX_DIM + 1);
  // worst-case width bound: MAX_DIM squares of CW-bit differences
  localparam int SUM_W = 2 * CW + CNT_W;

  eda_qstat_t        qstat;
  logic              push;
  logic              pop;
  logic [SUM_W:0]    push_data;
  logic [SUM_W:0]    rd_data;
  logic [DIST_W-1:0] distance;

  eda_front #(
    .MAX_DIM   (MAX_DIM),
    .COORD_BITS(COORD_BITS),
    .SUM_W     (SUM_W)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .coord_a  (s_tdata[COORD_W-1:0]),
    .coord_b  (s_tdata[2*COORD_W-1:COORD_W]),
    .s_tlast  (s_tlast),
    .qstat    (qstat),
    .push     (push),
    .push_data(push_data)
  );

  // entry: {overflow, sum of squares}
  eda_queue #(
    .W(SUM_W + 1)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (push),
    .wr_data(push_data),
    .pop    (pop),
    .rd_data(rd_data),
    .qstat  (qstat)
  );

  eda_sqrt #(
    .SUM_W(SUM_W)
  ) u_sqrt (
    .clk     (clk),
    .rst     (rst),
    .qstat   (qstat),
    .rd_data (rd_data),
    .pop     (pop),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .distance(distance),
    .overflow(m_tuser)
  );

  assign m_tdata = OUT_TDATA_W'(distance);

endmodule
